// ----- rtl/core/bhgc_pkg.sv -----
// ----------------------------------------------------------------------------
// bhgc_pkg
// Shared types and constants for the bucketed hash group counter.
// ----------------------------------------------------------------------------
package bhgc_pkg;

  localparam int LANES_DEF       = 16;
  localparam int MAX_BUCKETS_DEF = 1024;
  localparam int KEY_W           = 32;
  localparam int CNT_W           = 32;
  localparam int IDX_W           = 14;
  localparam int CFG_W           = 11;

  localparam logic [1:0] ST_NEW   = 2'd0;
  localparam logic [1:0] ST_EXIST = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_ZERO  = 2'd3;

  localparam logic REQ_COUNT = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] slot_index;
    logic             batch_end;
  } in_item_t;

  typedef struct packed {
    logic [KEY_W-1:0] slot_key;
    logic [CNT_W-1:0] slot_count;
    logic [1:0]       status;
    logic             batch_done;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input item
    logic clr_step;  // write zero row at clear address
    logic div_start;
    logic div_step;
    logic rd_slot;   // issue read of slot
    logic eval;      // compare lanes, latch decision
    logic wr_back;   // write row back
    logic next_bkt;  // advance probe
    logic res_zero;
    logic res_full;
    logic res_slot;
    logic res_hit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic div_done;
    logic is_read;
    logic key_zero;
    logic hit;
    logic has_free;
    logic probes_done;
  } sts_t;

endpackage

// ----- rtl/core/bhgc_ram.sv -----
// ----------------------------------------------------------------------------
// bhgc_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module bhgc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/bhgc_datapath.sv -----
// ----------------------------------------------------------------------------
// bhgc_datapath
// Bucket memory, serial modulo unit, lane compare and result register.
// ----------------------------------------------------------------------------
module bhgc_datapath #(
  parameter int LANES       = bhgc_pkg::LANES_DEF,
  parameter int MAX_BUCKETS = bhgc_pkg::MAX_BUCKETS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  bhgc_pkg::in_item_t               item,
  input  logic                             cfg_we,
  input  logic [bhgc_pkg::CFG_W-1:0]       cfg_data,
  input  bhgc_pkg::cmd_t                   cmd,
  output bhgc_pkg::sts_t                   sts,
  output bhgc_pkg::out_item_t              res
);

  localparam int BW    = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int NW    = $clog2(MAX_BUCKETS + 1);
  localparam int LW    = $clog2(LANES);
  localparam int SLOTS = LANES * MAX_BUCKETS;
  localparam int ROW_W = LANES * 64;
  localparam int KW    = bhgc_pkg::KEY_W;

  logic [bhgc_pkg::CFG_W-1:0] buckets_in_use;
  logic [NW-1:0] nb;
  bhgc_pkg::in_item_t cur;
  logic [BW-1:0] bkt, clr_addr;
  logic [NW-1:0] probe_cnt;
  logic [KW:0]   rem;
  logic [KW-1:0] quo;
  logic [5:0]    div_cnt;
  logic [ROW_W-1:0] rdata, row, wrow;
  logic [BW-1:0] raddr, waddr;
  logic          we;
  logic [LW-1:0] hit_lane, free_lane, slot_lane;
  logic          hit, has_free;
  logic          in_range;
  logic [LANES-1:0] hit_vec, free_vec;
  logic [KW:0]   rem_sh;

  always_comb begin
    if (buckets_in_use == '0) begin
      nb = NW'(1);
    end else if ({21'd0, buckets_in_use} > 32'(MAX_BUCKETS)) begin
      nb = NW'(MAX_BUCKETS);
    end else begin
      nb = NW'(buckets_in_use);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buckets_in_use <= bhgc_pkg::CFG_W'(MAX_BUCKETS);
      clr_addr <= '0;
      div_cnt <= '0;
    end else begin
      if (cfg_we) begin
        buckets_in_use <= cfg_data;
      end
      if (cmd.clr_step) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.div_start) begin
        div_cnt <= 6'd32;
      end else if (cmd.div_step && div_cnt != 0) begin
        div_cnt <= div_cnt - 1'b1;
      end
    end
  end

  assign sts.clr_last = (32'(clr_addr) == 32'(MAX_BUCKETS - 1));

  // restoring division, one quotient bit per cycle
  assign rem_sh = {rem[KW-1:0], quo[KW-1]};
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur <= item;
    end
    if (cmd.div_start) begin
      rem <= '0;
      quo <= item.key;
    end else if (cmd.div_step && div_cnt != 0) begin
      if (rem_sh >= (KW+1)'(nb)) begin
        rem <= rem_sh - (KW+1)'(nb);
      end else begin
        rem <= rem_sh;
      end
      quo <= {quo[KW-2:0], 1'b0};
    end
  end
  assign sts.div_done = (div_cnt == 0);

  always_ff @(posedge clk) begin
    if (cmd.div_step && div_cnt == 6'd1) begin
      bkt <= '0;
    end
    if (cmd.div_step && div_cnt == 0) begin
      bkt <= BW'(rem);
      probe_cnt <= '0;
    end else if (cmd.next_bkt) begin
      bkt <= (32'(bkt) + 1 == 32'(nb)) ? '0 : bkt + 1'b1;
      probe_cnt <= probe_cnt + 1'b1;
    end
  end
  assign sts.probes_done = (32'(probe_cnt) + 1 >= 32'(nb));

  assign in_range  = (32'(cur.slot_index) < 32'(SLOTS));
  assign slot_lane = LW'(cur.slot_index);

  always_comb begin
    raddr = bkt;
    if (cmd.rd_slot) begin
      raddr = BW'(cur.slot_index >> LW);
    end
  end

  bhgc_ram #(.WIDTH(ROW_W), .DEPTH(MAX_BUCKETS)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wrow),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    hit_lane  = '0;
    free_lane = '0;
    for (int l = LANES - 1; l >= 0; l--) begin
      hit_vec[l]  = (rdata[l*64 +: KW] == cur.key);
      free_vec[l] = (rdata[l*64 +: KW] == '0);
      if (hit_vec[l]) hit_lane = LW'(l);
      if (free_vec[l]) free_lane = LW'(l);
    end
  end
  assign sts.hit      = hit;
  assign sts.has_free = has_free;
  assign sts.is_read  = (cur.req_type == bhgc_pkg::REQ_READ);
  assign sts.key_zero = (cur.key == '0);

  logic [LW-1:0] sel_lane;
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      row      <= rdata;
      hit      <= |hit_vec;
      has_free <= |free_vec;
      sel_lane <= (|hit_vec) ? hit_lane : free_lane;
    end
  end

  logic [KW-1:0] old_cnt, new_cnt;
  assign old_cnt = row[sel_lane*64 + 32 +: 32];
  assign new_cnt = hit ? ((old_cnt == '1) ? old_cnt : old_cnt + 1'b1) : 32'd1;

  always_comb begin
    wrow  = row;
    waddr = bkt;
    we    = cmd.wr_back;
    if (cmd.clr_step) begin
      wrow  = '0;
      waddr = clr_addr;
      we    = 1'b1;
    end else begin
      wrow[sel_lane*64 +: 64] = {new_cnt, cur.key};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_zero || cmd.res_full) begin
      res.slot_key   <= '0;
      res.slot_count <= '0;
      res.status     <= cmd.res_zero ? bhgc_pkg::ST_ZERO : bhgc_pkg::ST_FULL;
      res.batch_done <= cur.batch_end;
    end else if (cmd.res_slot) begin
      res.slot_key   <= in_range ? rdata[slot_lane*64 +: 32] : '0;
      res.slot_count <= in_range ? rdata[slot_lane*64 + 32 +: 32] : '0;
      res.status     <= bhgc_pkg::ST_NEW;
      res.batch_done <= cur.batch_end;
    end else if (cmd.res_hit) begin
      res.slot_key   <= cur.key;
      res.slot_count <= new_cnt;
      res.status     <= hit ? bhgc_pkg::ST_EXIST : bhgc_pkg::ST_NEW;
      res.batch_done <= cur.batch_end;
    end
  end

endmodule

// ----- rtl/core/bhgc_ctrl.sv -----
// ----------------------------------------------------------------------------
// bhgc_ctrl
// Sequencer for clearing, hashing, probing and result handoff.
// ----------------------------------------------------------------------------
module bhgc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  bhgc_pkg::sts_t sts,
  output bhgc_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_DIV, S_RD, S_EVAL, S_DECIDE, S_SLOT, S_RESULT
  } state_t;

  state_t state, state_next;
  logic res_load;

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);

  always_comb begin
    cmd = '0;
    state_next = state;
    res_load = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          cmd.div_start = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.is_read) begin
          cmd.rd_slot = 1'b1;
          state_next = S_SLOT;
        end else if (sts.key_zero) begin
          cmd.res_zero = 1'b1;
          res_load = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_next = S_RD;
      end
      S_RD: begin
        state_next = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts.hit || sts.has_free) begin
          cmd.wr_back = 1'b1;
          cmd.res_hit = 1'b1;
          res_load = 1'b1;
          state_next = S_IDLE;
        end else if (sts.probes_done) begin
          cmd.res_full = 1'b1;
          res_load = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.next_bkt = 1'b1;
          state_next = S_RD;
        end
      end
      S_SLOT: begin
        cmd.rd_slot = 1'b1;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        cmd.res_slot = 1'b1;
        res_load = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !in_ready) else $error("accept during clear");
  a_res_when_free: assert property (@(posedge clk) disable iff (rst)
    res_load |-> !out_valid) else $error("result overwritten");
  a_one_write: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_back |=> state == S_IDLE) else $error("write not final");
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_DECODE) else $error("lost item");
`endif

endmodule

// ----- rtl/core/bucketed_hash_group_count.sv -----
// ----------------------------------------------------------------------------
// bucketed_hash_group_count
// Counts 32-bit keys in a bucketed hash table with linear probing.
// ----------------------------------------------------------------------------
// channel | signals                        | payload
// in      | in_valid / in_ready            | bhgc_pkg::in_item_t
// out     | out_valid / out_ready          | bhgc_pkg::out_item_t
// cfg     | cfg_valid / cfg_ready          | buckets_in_use, 11 bits
//
// read request: decode, slot read, result; zero key: decided in decode.
// count request: decode and the serial modulo, then read, compare and decide per bucket probed.
// reset clears the table one bucket per cycle, with no accepts until done.
// a finished result waits in the output register; the next item is taken
// in the same cycle as the result transfer.
// ----------------------------------------------------------------------------
module bucketed_hash_group_count #(
  parameter int LANES       = bhgc_pkg::LANES_DEF,
  parameter int MAX_BUCKETS = bhgc_pkg::MAX_BUCKETS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  bhgc_pkg::in_item_t         in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output bhgc_pkg::out_item_t        out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [bhgc_pkg::CFG_W-1:0] cfg_data
);

  bhgc_pkg::cmd_t cmd;
  bhgc_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  bhgc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bhgc_datapath #(.LANES(LANES), .MAX_BUCKETS(MAX_BUCKETS)) u_dp (
    .clk     (clk),
    .rst     (rst),
    .item    (in_data),
    .cfg_we  (cfg_valid && cfg_ready),
    .cfg_data(cfg_data),
    .cmd     (cmd),
    .sts     (sts),
    .res     (out_data)
  );

endmodule
